FILE: hdl/dtc_pkg.sv
// Shared constants and types for the dynamic triangle counter.
package dtc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERTEX_W     = 6;
    localparam int TOTAL_W      = 16;
    localparam int COMMON_W     = 6;
    localparam int STATUS_W     = 2;

    localparam int ROW_W       = MAX_VERTICES;
    localparam int ADDR_W      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = (ROW_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W       = NUM_CHUNKS * CHUNK_W;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CNT_W       = $clog2(ROW_W + 1);

    localparam logic [STATUS_W-1:0] STATUS_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SELF_LOOP = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd3;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } adj_mem_req_t;

    typedef struct packed {
        logic clear;
        logic step;
    } pop_ctrl_t;

endpackage

FILE: hdl/dtc_adj_mem.sv
// Adjacency row memory: one write port, two registered read ports, per-row valid bits.
module dtc_adj_mem
    import dtc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  adj_mem_req_t req,
    input  row_t         wr_data,
    output row_t         rd_row_a,
    output row_t         rd_row_b
);

    row_t                    adj_mem [MAX_VERTICES];
    row_t                    data_a_reg;
    row_t                    data_b_reg;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic                    valid_a_reg;
    logic                    valid_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            adj_mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            data_a_reg <= adj_mem[req.rd_addr_a];
            data_b_reg <= adj_mem[req.rd_addr_b];
        end
    end

    // rows never written read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                valid_a_reg <= valid_reg[req.rd_addr_a];
                valid_b_reg <= valid_reg[req.rd_addr_b];
            end
        end
    end

    assign rd_row_a = valid_a_reg ? data_a_reg : '0;
    assign rd_row_b = valid_b_reg ? data_b_reg : '0;

endmodule

FILE: hdl/dtc_popcnt.sv
// Shared chunk popcount and accumulator, one chunk per step.
module dtc_popcnt
    import dtc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pop_ctrl_t          ctrl,
    input  logic [CHUNK_W-1:0] chunk,
    output logic [CNT_W-1:0]   count
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [CNT_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.step)
        begin
            count_next = count_reg + pop_chunk(chunk);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

FILE: hdl/dynamic_triangle_counter_core.sv
// Dynamic triangle counter: top level with the per-item sequencer.
//
// One edge (node_a, node_b) is taken when start is high and busy is low.
// A valid edge reads both adjacency rows from the single row memory, runs
// the shared 16-bit popcount unit over the AND of the rows chunk by chunk,
// then makes one memory write per endpoint row; a duplicate in insert-only
// mode is ignored without a write. A self-loop or out-of-range edge gives
// its result the cycle after acceptance. The result shows on triangle_total,
// common_neighbours and edge_status for exactly one cycle while done is
// high; the receiver cannot stall it, and busy is already low in that cycle
// so the next edge may be taken. No clearing pass is needed after reset.
// insert_only is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
module dynamic_triangle_counter_core
    import dtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [VERTEX_W-1:0] node_a,
    input  logic [VERTEX_W-1:0] node_b,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    output logic                done,
    output logic [TOTAL_W-1:0]  triangle_total,
    output logic [COMMON_W-1:0] common_neighbours,
    output logic [STATUS_W-1:0] edge_status
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;
    localparam logic [2:0] ST_COUNT   = 3'd2;
    localparam logic [2:0] ST_DECIDE  = 3'd3;
    localparam logic [2:0] ST_WRITE_B = 3'd4;

    localparam logic [VERTEX_W:0]      VERTEX_LIM = (VERTEX_W + 1)'(MAX_VERTICES);
    localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);

    logic [2:0]             state_reg,       state_next;
    logic [ADDR_W-1:0]      a_reg,           a_next;
    logic [ADDR_W-1:0]      b_reg,           b_next;
    logic [CHUNK_IDX_W-1:0] chunk_idx_reg,   chunk_idx_next;
    logic [TOTAL_W-1:0]     total_reg,       total_next;
    logic                   insert_only_reg, insert_only_next;
    logic                   done_reg,        done_next;
    logic [COMMON_W-1:0]    common_reg,      common_next;
    logic [STATUS_W-1:0]    status_reg,      status_next;

    adj_mem_req_t       mem_req;
    row_t               mem_wr_data;
    row_t               row_a;
    row_t               row_b;
    pop_ctrl_t          pop_ctrl;
    logic [CNT_W-1:0]   pop_count;
    logic [PAD_W-1:0]   and_pad;
    logic [CHUNK_W-1:0] chunk;
    logic               present;
    logic               bad_edge;
    logic [TOTAL_W-1:0] count_ext;

    dtc_adj_mem u_adj_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .wr_data  (mem_wr_data),
        .rd_row_a (row_a),
        .rd_row_b (row_b)
    );

    dtc_popcnt u_popcnt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pop_ctrl),
        .chunk (chunk),
        .count (pop_count)
    );

    assign and_pad   = PAD_W'(row_a & row_b);
    assign chunk     = and_pad[CHUNK_W * chunk_idx_reg +: CHUNK_W];
    assign present   = row_a[b_reg];
    assign count_ext = TOTAL_W'(pop_count);
    assign bad_edge  = (node_a == node_b)
                    || ({1'b0, node_a} >= VERTEX_LIM)
                    || ({1'b0, node_b} >= VERTEX_LIM);

    always_comb
    begin
        state_next       = state_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        chunk_idx_next   = chunk_idx_reg;
        total_next       = total_reg;
        insert_only_next = insert_only_reg;
        done_next        = 1'b0;
        common_next      = common_reg;
        status_next      = status_reg;

        mem_req           = '0;
        mem_req.rd_addr_a = node_a[ADDR_W-1:0];
        mem_req.rd_addr_b = node_b[ADDR_W-1:0];
        mem_req.wr_addr   = a_reg;
        mem_wr_data       = row_a ^ (ROW_W'(1) << b_reg);
        pop_ctrl          = '0;

        if (cfg_wr_en)
        begin
            insert_only_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (bad_edge)
                    begin
                        done_next   = 1'b1;
                        common_next = '0;
                        status_next = STATUS_SELF_LOOP;
                    end
                    else
                    begin
                        mem_req.rd_en  = 1'b1;
                        pop_ctrl.clear = 1'b1;
                        a_next         = node_a[ADDR_W-1:0];
                        b_next         = node_b[ADDR_W-1:0];
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                chunk_idx_next = '0;
                state_next     = ST_COUNT;
            end
            ST_COUNT:
            begin
                pop_ctrl.step  = 1'b1;
                chunk_idx_next = chunk_idx_reg + 1'b1;
                if (chunk_idx_reg == LAST_CHUNK)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                common_next = COMMON_W'(pop_count);
                if (present && insert_only_reg)
                begin
                    status_next = STATUS_DUPLICATE;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // toggle b in row a; row b follows next cycle
                    mem_req.wr_en = 1'b1;
                    if (present)
                    begin
                        total_next  = total_reg - count_ext;
                        status_next = STATUS_REMOVED;
                    end
                    else
                    begin
                        total_next  = total_reg + count_ext;
                        status_next = STATUS_ADDED;
                    end
                    state_next = ST_WRITE_B;
                end
            end
            ST_WRITE_B:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = b_reg;
                mem_wr_data     = row_b ^ (ROW_W'(1) << a_reg);
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chunk_idx_reg   <= '0;
            total_reg       <= '0;
            insert_only_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chunk_idx_reg   <= chunk_idx_next;
            total_reg       <= total_next;
            insert_only_reg <= insert_only_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        common_reg <= common_next;
        status_reg <= status_next;
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign triangle_total    = total_reg;
    assign common_neighbours = common_reg;
    assign edge_status       = status_reg;

endmodule

FILE: hdl/dtc_checker.sv
// Port-level checks for the triangle counter, bound to the top level.
module dtc_checker
    import dtc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [VERTEX_W-1:0] node_a,
    input logic [VERTEX_W-1:0] node_b,
    input logic                done,
    input logic [TOTAL_W-1:0]  triangle_total,
    input logic [COMMON_W-1:0] common_neighbours,
    input logic [STATUS_W-1:0] edge_status
);

    // results only appear once the sequencer has released
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (node_a == node_b))
        |=> (done && (edge_status == STATUS_SELF_LOOP) && (common_neighbours == '0)))
        else $error("self-loop item did not give an immediate ignored result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (node_a != node_b)) |=> (busy && !done))
        else $error("edge item did not start the sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((edge_status == STATUS_SELF_LOOP) || (edge_status == STATUS_DUPLICATE)))
        |-> (triangle_total == $past(triangle_total)))
        else $error("ignored item changed the total");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (edge_status == STATUS_ADDED))
        |-> (triangle_total == TOTAL_W'($past(triangle_total, 2) + TOTAL_W'(common_neighbours))))
        else $error("added edge did not add its common neighbours to the total");

endmodule

bind dynamic_triangle_counter_core dtc_checker u_dtc_checker (.*);
